>>> rtl/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Holds the per-item job descriptor that travels from the classifier to the
// arithmetic pipeline, plus the codes for which quaternion part leads.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Matrix element and output word width.
    localparam int ELEM_W = 16;
    // Magnitude of a sum or difference of two elements.
    localparam int MAG_W = 17;
    // Number of matrix elements per item and quaternion parts per result.
    localparam int NUM_ELEM = 9;
    localparam int NUM_PART = 4;

    // Saturation bounds.
    localparam int WORD_MAX = 32767;
    localparam int WORD_MIN_MAG = 32768;

    // Queue between the classifier and the arithmetic pipeline.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Which quaternion part comes from the square root.
    typedef logic [1:0] t_lead;
    localparam t_lead LEAD_W = 2'd0;
    localparam t_lead LEAD_X = 2'd1;
    localparam t_lead LEAD_Y = 2'd2;
    localparam t_lead LEAD_Z = 2'd3;

    // Job descriptor. The three scaled parts are ordered by increasing output
    // slot, with the leading slot left out.
    typedef struct packed {
        logic                        deg;
        t_lead                       lead;
        logic [2:0]                  neg;
        logic [2:0][MAG_W-1:0]       mag;
    } t_info;

endpackage
`default_nettype wire

>>> rtl/rmq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front: input classifier
// Takes a matrix, picks the leading quaternion part (Shepperd's rule), forms
// the root argument and the three signed sums or differences, and holds the
// job in a register until the queue takes it.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic [rmq_pkg::NUM_ELEM*rmq_pkg::ELEM_W-1:0] i_data,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output rmq_pkg::t_info                                o_info,
    output logic [((FRAC_BITS > 17) ? FRAC_BITS : 17)+1-1:0] o_arg
);

    localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

    logic signed [rmq_pkg::ELEM_W-1:0] e [rmq_pkg::NUM_ELEM];
    logic signed [17:0]                trace;
    logic signed [AW-1:0]              a;
    logic signed [rmq_pkg::MAG_W-1:0]  d [3];
    rmq_pkg::t_lead                    lead;
    rmq_pkg::t_info                    n_info;
    logic [AW-2:0]                     n_arg;

    logic                              r_vld;
    rmq_pkg::t_info                    r_info;
    logic [AW-2:0]                     r_arg;

    // Unpack the elements, row by row.
    always_comb begin
        for (int n = 0; n < rmq_pkg::NUM_ELEM; n++) begin
            e[n] = signed'(i_data[n*rmq_pkg::ELEM_W +: rmq_pkg::ELEM_W]);
        end
    end

    // Trace and choice of the leading part; ties go to the lower index.
    always_comb begin
        trace = 18'(e[0]) + 18'(e[4]) + 18'(e[8]);
        if (trace > 18'sd0) begin
            lead = rmq_pkg::LEAD_W;
        end else if (e[4] > e[0]) begin
            lead = (e[8] > e[4]) ? rmq_pkg::LEAD_Z : rmq_pkg::LEAD_Y;
        end else begin
            lead = (e[8] > e[0]) ? rmq_pkg::LEAD_Z : rmq_pkg::LEAD_X;
        end
    end

    // Root argument and the off-diagonal terms for each leading part.
    always_comb begin
        unique case (lead)
            rmq_pkg::LEAD_W: begin
                a    = AW'(trace) + ONE;
                d[0] = 17'(e[7]) - 17'(e[5]);
                d[1] = 17'(e[2]) - 17'(e[6]);
                d[2] = 17'(e[3]) - 17'(e[1]);
            end
            rmq_pkg::LEAD_X: begin
                a    = AW'(e[0]) - AW'(e[4]) - AW'(e[8]) + ONE;
                d[0] = 17'(e[7]) - 17'(e[5]);
                d[1] = 17'(e[3]) + 17'(e[1]);
                d[2] = 17'(e[6]) + 17'(e[2]);
            end
            rmq_pkg::LEAD_Y: begin
                a    = AW'(e[4]) - AW'(e[8]) - AW'(e[0]) + ONE;
                d[0] = 17'(e[2]) - 17'(e[6]);
                d[1] = 17'(e[1]) + 17'(e[3]);
                d[2] = 17'(e[7]) + 17'(e[5]);
            end
            default: begin
                a    = AW'(e[8]) - AW'(e[0]) - AW'(e[4]) + ONE;
                d[0] = 17'(e[3]) - 17'(e[1]);
                d[1] = 17'(e[2]) + 17'(e[6]);
                d[2] = 17'(e[5]) + 17'(e[7]);
            end
        endcase
    end

    // Build the job: a non-positive argument marks the item degenerate.
    always_comb begin
        n_info.lead = lead;
        n_info.deg  = a[AW-1] || (a == '0);
        n_arg       = n_info.deg ? '0 : a[AW-2:0];
        for (int n = 0; n < 3; n++) begin
            n_info.neg[n] = d[n][rmq_pkg::MAG_W-1];
            n_info.mag[n] = d[n][rmq_pkg::MAG_W-1] ? unsigned'(-d[n]) : unsigned'(d[n]);
        end
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_info  = r_info;
    assign o_arg   = r_arg;

    // Job holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_info <= n_info;
            r_arg  <= n_arg;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rmq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_fifo: job queue
// A short first-in first-out queue that lets the classifier and the
// arithmetic pipeline stall independently.
// ----------------------------------------------------------------------------
module rmq_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data
);

    logic [W-1:0]                r_mem [rmq_pkg::QUEUE_DEPTH];
    logic [rmq_pkg::QPTR_W-1:0]  r_wp;
    logic [rmq_pkg::QPTR_W-1:0]  r_rp;
    logic [rmq_pkg::QCNT_W-1:0]  r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_ready = (r_cnt != rmq_pkg::QCNT_W'(rmq_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rmq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_back: arithmetic pipeline
// Pipelined square root (one result bit per stage), pipelined reciprocal
// division (one quotient bit per stage), split multiply, then saturation and
// placement of the four parts into the output register.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_pop,
    input  wire rmq_pkg::t_info        i_info,
    input  wire logic [((FRAC_BITS > 17) ? FRAC_BITS : 17)+1-1:0] i_arg,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [rmq_pkg::NUM_PART*rmq_pkg::ELEM_W-1:0] o_data,
    output logic                       o_deg
);

    localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int VW = AW - 1 + FRAC_BITS;
    localparam int SW = (VW + 1) / 2;
    localparam int H2 = FRAC_BITS / 2;
    localparam int QW = 2 * FRAC_BITS - H2;
    localparam int LW = (QW + 1) / 2;
    localparam int HW = QW - LW;
    localparam int PW = rmq_pkg::MAG_W + QW;
    localparam int TW = PW - FRAC_BITS;
    localparam int D0 = SW + 1;
    localparam int M  = D0 + QW + 1;
    localparam int O  = M + 1;
    localparam logic [SW:0] DIV_INIT = (SW + 1)'(1) << (H2 - 1);

    logic           adv;
    logic [O:0]     r_vld;
    rmq_pkg::t_info r_inf [M+1];

    // Square root stages.
    logic [2*SW-1:0] r_sv [SW+1];
    logic [SW+1:0]   r_sr [SW+1];
    logic [SW-1:0]   r_sq [SW+1];
    logic [2*SW-1:0] n_sv [1:SW];
    logic [SW+1:0]   n_sr [1:SW];
    logic [SW-1:0]   n_sq [1:SW];

    // Division stages.
    logic [SW:0]     r_dr [QW+1];
    logic [SW-1:0]   r_ds [QW+1];
    logic [QW-1:0]   r_dq [QW+1];
    logic [SW:0]     n_dr [1:QW];
    logic [SW-1:0]   n_ds [1:QW];
    logic [QW-1:0]   n_dq [1:QW];

    // Multiply stage.
    logic [rmq_pkg::MAG_W+LW-1:0] r_plo [3];
    logic [rmq_pkg::MAG_W+HW-1:0] r_phi [3];
    logic [SW-2:0]                r_lv;

    // Output stage.
    logic [rmq_pkg::ELEM_W-1:0]   part [3];
    logic [rmq_pkg::ELEM_W-1:0]   lsat;
    logic [rmq_pkg::ELEM_W-1:0]   n_q [rmq_pkg::NUM_PART];
    logic [rmq_pkg::ELEM_W-1:0]   r_q [rmq_pkg::NUM_PART];
    logic                         r_odeg;

    // The whole pipeline moves unless a result waits at a stalled output.
    assign adv   = !r_vld[O] || i_ready;
    assign o_pop = adv;

    // Square root: bring down two bits and try one root bit per stage.
    always_comb begin
        logic [SW+1:0] t;
        logic [SW+1:0] trial;
        for (int g = 1; g <= SW; g++) begin
            t     = {r_sr[g-1][SW-1:0], r_sv[g-1][2*SW-1 -: 2]};
            trial = {r_sq[g-1], 2'b01};
            n_sv[g] = r_sv[g-1] << 2;
            if (t >= trial) begin
                n_sr[g] = t - trial;
                n_sq[g] = {r_sq[g-1][SW-2:0], 1'b1};
            end else begin
                n_sr[g] = t;
                n_sq[g] = {r_sq[g-1][SW-2:0], 1'b0};
            end
        end
    end

    // Reciprocal: restoring division of a power of two by the root.
    always_comb begin
        logic [SW:0] dt;
        for (int g = 1; g <= QW; g++) begin
            dt      = {r_dr[g-1][SW-1:0], 1'b0};
            n_ds[g] = r_ds[g-1];
            if (dt >= {1'b0, r_ds[g-1]}) begin
                n_dr[g] = dt - {1'b0, r_ds[g-1]};
                n_dq[g] = {r_dq[g-1][QW-2:0], 1'b1};
            end else begin
                n_dr[g] = dt;
                n_dq[g] = {r_dq[g-1][QW-2:0], 1'b0};
            end
        end
    end

    // Recombine the partial products, truncate, saturate and place the parts.
    always_comb begin
        logic [PW-1:0]                prod;
        logic [TW-1:0]                tr;
        logic [rmq_pkg::MAG_W-1:0]    cm;
        logic [SW+15:0]               ext;
        for (int n = 0; n < 3; n++) begin
            prod = (PW'(r_phi[n]) << LW) + PW'(r_plo[n]);
            tr   = prod[PW-1:FRAC_BITS];
            if (r_inf[M].neg[n]) begin
                cm = (tr > TW'(rmq_pkg::WORD_MIN_MAG)) ?
                     rmq_pkg::MAG_W'(rmq_pkg::WORD_MIN_MAG) : tr[rmq_pkg::MAG_W-1:0];
                part[n] = rmq_pkg::ELEM_W'(-cm);
            end else begin
                cm = (tr > TW'(rmq_pkg::WORD_MAX)) ?
                     rmq_pkg::MAG_W'(rmq_pkg::WORD_MAX) : tr[rmq_pkg::MAG_W-1:0];
                part[n] = cm[rmq_pkg::ELEM_W-1:0];
            end
        end
        ext  = (SW + 16)'(r_lv);
        lsat = (ext > (SW + 16)'(rmq_pkg::WORD_MAX)) ?
               rmq_pkg::ELEM_W'(rmq_pkg::WORD_MAX) : ext[rmq_pkg::ELEM_W-1:0];
        for (int n = 0; n < rmq_pkg::NUM_PART; n++) begin
            if (r_inf[M].deg) begin
                n_q[n] = '0;
            end else if (2'(n) == r_inf[M].lead) begin
                n_q[n] = lsat;
            end else if (2'(n) < r_inf[M].lead) begin
                n_q[n] = part[n];
            end else begin
                n_q[n] = part[n-1];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[O-1:0], i_valid};
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_inf[0] <= i_info;
            for (int g = 1; g <= M; g++) begin
                r_inf[g] <= r_inf[g-1];
            end
            r_sv[0] <= (2 * SW)'(i_arg) << FRAC_BITS;
            r_sr[0] <= '0;
            r_sq[0] <= '0;
            for (int g = 1; g <= SW; g++) begin
                r_sv[g] <= n_sv[g];
                r_sr[g] <= n_sr[g];
                r_sq[g] <= n_sq[g];
            end
            r_dr[0] <= DIV_INIT;
            r_ds[0] <= r_sq[SW];
            r_dq[0] <= '0;
            for (int g = 1; g <= QW; g++) begin
                r_dr[g] <= n_dr[g];
                r_ds[g] <= n_ds[g];
                r_dq[g] <= n_dq[g];
            end
            for (int n = 0; n < 3; n++) begin
                r_plo[n] <= (rmq_pkg::MAG_W + LW)'(r_inf[M-1].mag[n]) *
                            (rmq_pkg::MAG_W + LW)'(r_dq[QW][LW-1:0]);
                r_phi[n] <= (rmq_pkg::MAG_W + HW)'(r_inf[M-1].mag[n]) *
                            (rmq_pkg::MAG_W + HW)'(r_dq[QW][QW-1:LW]);
            end
            r_lv <= r_ds[QW][SW-1:1];
            for (int n = 0; n < rmq_pkg::NUM_PART; n++) begin
                r_q[n] <= n_q[n];
            end
            r_odeg <= r_inf[M].deg;
        end
    end

    assign o_valid = r_vld[O];
    assign o_deg   = r_odeg;
    assign o_data  = {r_q[3], r_q[2], r_q[1], r_q[0]};

    // A degenerate result carries all-zero parts.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[O] && r_odeg |-> (r_q[0] == '0 && r_q[1] == '0 && r_q[2] == '0
                                && r_q[3] == '0))
        else $error("degenerate result with nonzero parts");

    // A stalled pipeline keeps every item in place.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    // A job taken from the queue enters the first stage.
    a_pop_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && i_valid |=> r_vld[0])
        else $error("popped job lost");

endmodule
`default_nettype wire

>>> rtl/rotation_matrix_to_quaternion_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top: rotation matrix to unit quaternion
// Converts a 3x3 fixed-point rotation matrix into a quaternion by Shepperd's
// method: square root, reciprocal and scaled off-diagonal terms.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one matrix per transfer, nine signed elements
//   with FRAC_BITS fraction bits. The output stream carries one quaternion per
//   transfer; tuser flags a degenerate matrix, whose parts are then zero.
//   The pipeline has SW = ceil((AW - 1 + FRAC_BITS) / 2) square root stages
//   and QW = 2*FRAC_BITS - FRAC_BITS/2 division stages. Throughput is one
//   matrix per cycle while the receiver does not stall: the root and the
//   reciprocal each resolve one bit per pipeline stage, so a new item enters
//   every cycle unless a result waits at a stalled output.
//   Reset empties the classifier register, the queue and the pipeline; no
//   result is pending afterwards. When the receiver stalls, the result stays
//   in the output register, the pipeline holds, and the four-entry queue plus
//   the classifier register keep taking input until they fill up.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each, lowest first)
    input  wire logic [143:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // qw, qx, qy, qz (16 bits each, lowest first)
    output logic [63:0]       o_m_axis_tdata,
    // degenerate
    output logic [0:0]        o_m_axis_tuser
);

    localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int QDW = $bits(rmq_pkg::t_info) + AW - 1;

    logic           f_valid;
    logic           q_ready;
    rmq_pkg::t_info f_info;
    logic [AW-2:0]  f_arg;
    logic           q_valid;
    logic           b_pop;
    logic [QDW-1:0] q_data;
    logic           b_deg;

    // Classifier.
    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (q_ready),
        .o_info  (f_info),
        .o_arg   (f_arg)
    );

    // Job queue.
    rmq_fifo #(.W(QDW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_data  ({f_info, f_arg}),
        .o_valid (q_valid),
        .i_pop   (b_pop),
        .o_data  (q_data)
    );

    // Arithmetic pipeline.
    rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (b_pop),
        .i_info  (rmq_pkg::t_info'(q_data[QDW-1:AW-1])),
        .i_arg   (q_data[AW-2:0]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_deg   (b_deg)
    );

    assign o_m_axis_tuser = b_deg;

endmodule
`default_nettype wire

>>> test/rotation_matrix_to_quaternion_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top_test: self-checking stream testbench
// Sends rotation matrices through the converter and checks every quaternion
// against a fixed-point Shepperd predictor, or known values for the identity
// and axis rows. The run starts with a directed table of extremes, ties and
// each leading branch, then moves on to random matrices. Both sides idle at random.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top_test;

    localparam int FRAC = 14;
    localparam int ONE = 1 << FRAC;
    localparam int NUM_RAND = 1650;
    localparam int LATENCY = 42;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        deg;
        logic [63:0] quat;
    } t_quat_res;

    typedef struct {
        logic [143:0] mat;
        logic         known;
        t_quat_res    res;
    } t_row;

    logic         clk;
    logic         rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [143:0] s_data;
    logic         m_valid;
    logic         m_ready;
    logic [63:0]  m_data;
    logic [0:0]   m_user;

    t_quat_res    quat_queue[$];
    t_row         rows[$];
    int           mismatches;
    int           cycles;
    bit           sending_done;

    rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root by bit-pair restoring.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Off-diagonal term times 0.5/s, truncated toward zero.
    function automatic longint scaled_term(longint d, longint unsigned r);
        longint unsigned mag;
        longint p;
        mag = (d < 0) ? -d : d;
        p = longint'((mag * r) >> FRAC);
        return (d < 0) ? -p : p;
    endfunction

    // Shepperd conversion in fixed point.
    function automatic t_quat_res quat_of_matrix(logic [143:0] mat);
        longint m[3][3];
        longint q[3];
        longint w, a, tr;
        longint unsigned s, r;
        int i, j, k, n;
        t_quat_res res;
        for (n = 0; n < 9; n++) m[n / 3][n % 3] = longint'($signed(mat[16*n +: 16]));
        q[0] = 0; q[1] = 0; q[2] = 0;
        i = 0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            a = tr + ONE;
        end else begin
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            a = m[i][i] - (m[j][j] + m[k][k]) + ONE;
        end
        if (a <= 0) begin
            res.deg = 1'b1;
            res.quat = '0;
            return res;
        end
        s = root_floor(longint'(a) << FRAC);
        if (s == 0) s = 1;
        r = (64'd1 << (2 * FRAC - 1)) / s;
        if (tr > 0) begin
            w = longint'(s >> 1);
            q[0] = scaled_term(m[2][1] - m[1][2], r);
            q[1] = scaled_term(m[0][2] - m[2][0], r);
            q[2] = scaled_term(m[1][0] - m[0][1], r);
        end else begin
            q[i] = longint'(s >> 1);
            w = scaled_term(m[k][j] - m[j][k], r);
            q[j] = scaled_term(m[j][i] + m[i][j], r);
            q[k] = scaled_term(m[k][i] + m[i][k], r);
        end
        res.deg = 1'b0;
        res.quat = {clamp16(q[2]), clamp16(q[1]), clamp16(q[0]), clamp16(w)};
        return res;
    endfunction

    function automatic logic [143:0] pack_mat(int e[9]);
        logic [143:0] v;
        for (int n = 0; n < 9; n++) v[16*n +: 16] = e[n][15:0];
        return v;
    endfunction

    // Random matrix: full-range elements or elements in [-ONE, ONE], some with one dominant diagonal.
    function automatic logic [143:0] random_matrix();
        int e[9];
        int kind;
        kind = $urandom_range(0, 9);
        for (int n = 0; n < 9; n++) begin
            if (kind < 2) e[n] = $urandom_range(0, 65535) - 32768;
            else e[n] = $urandom_range(0, 2 * ONE) - ONE;
        end
        if (kind >= 2 && kind < 6) begin
            // One dominant diagonal element with a non-positive trace.
            int d;
            d = $urandom_range(0, 2);
            e[0] = -$urandom_range(ONE / 2, ONE);
            e[4] = -$urandom_range(ONE / 2, ONE);
            e[8] = -$urandom_range(ONE / 2, ONE);
            e[4 * d] = $urandom_range(0, ONE);
        end
        return pack_mat(e);
    endfunction

    function automatic t_row row_of(int e[9], logic known, logic deg, logic [63:0] quat);
        t_row rw;
        rw.mat = pack_mat(e);
        rw.known = known;
        rw.res.deg = deg;
        rw.res.quat = quat;
        return rw;
    endfunction

    // Directed table: identity, each leading axis, ties, extremes.
    task automatic build_table();
        rows.push_back(row_of('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, 0, {48'd0, 16'h4000}));
        rows.push_back(row_of('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1, 0, {32'd0, 16'h4000, 16'd0}));
        rows.push_back(row_of('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 1, 0, {16'd0, 16'h4000, 32'd0}));
        rows.push_back(row_of('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1, 0, {16'h4000, 48'd0}));
        rows.push_back(row_of('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}, 0, 0, 0));
        rows.push_back(row_of('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 0, 0, 0));
        rows.push_back(row_of('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, 0, 0));
        rows.push_back(row_of('{-ONE, 5, 7, 3, -ONE, 9, 2, 4, -3 * ONE}, 0, 0, 0));
        rows.push_back(row_of('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
                              0, 0, 0));
        rows.push_back(row_of('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                -32768}, 0, 0, 0));
        rows.push_back(row_of('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                                32767}, 0, 0, 0));
        rows.push_back(row_of('{1, -32768, 32767, 32767, 0, -32768, -32768, 32767, -1}, 0, 0, 0));
        rows.push_back(row_of('{0, 32767, 0, 32767, 0, 0, 0, 0, -1}, 0, 0, 0));
        rows.push_back(row_of('{-1, -32768, -32768, 32767, -1, 32767, -32768, 32767, -1}, 0, 0, 0));
        rows.push_back(row_of('{11585, -11585, 0, 11585, 11585, 0, 0, 0, ONE}, 0, 0, 0));
        rows.push_back(row_of('{0, 0, ONE, 0, -ONE, 0, ONE, 0, 0}, 0, 0, 0));
    endtask

    // Send one matrix after a random gap; valid stays up when no gap follows.
    task automatic send_matrix(logic [143:0] mat, t_quat_res res);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= mat;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        quat_queue.push_back(res);
    endtask

    // Stimulus.
    initial begin
        t_quat_res res;
        logic [143:0] mat;
        s_valid = 1'b0;
        s_data = '0;
        rst_n = 1'b0;
        sending_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        build_table();
        foreach (rows[n]) begin
            res = rows[n].known ? rows[n].res : quat_of_matrix(rows[n].mat);
            send_matrix(rows[n].mat, res);
        end
        for (int n = 0; n < NUM_RAND; n++) begin
            if (n == NUM_RAND / 2) begin
                // Let the pipeline drain completely once.
                s_valid <= 1'b0;
                @(posedge clk);
                while (quat_queue.size() != 0) @(posedge clk);
            end
            mat = random_matrix();
            send_matrix(mat, quat_of_matrix(mat));
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver stalls.
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!m_valid) @(posedge clk);
        end
    end

    // Check each result transfer against the oldest prediction.
    always @(posedge clk) begin
        t_quat_res exp_res;
        if (rst_n && m_valid && m_ready) begin
            if (quat_queue.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %h deg %b", m_data, m_user);
            end else begin
                exp_res = quat_queue.pop_front();
                if (exp_res.quat !== m_data || exp_res.deg !== m_user[0]) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch exp %h deg %b, got %h deg %b",
                                 exp_res.quat, exp_res.deg, m_data, m_user);
                end
            end
        end
    end

    // End of run and cycle limit.
    initial begin
        mismatches = 0;
        cycles = 0;
        fork
            begin
                wait (sending_done);
                while (quat_queue.size() != 0) @(posedge clk);
                repeat (LATENCY + 20) @(posedge clk);
                if (mismatches == 0 && quat_queue.size() == 0) begin
                    $display("tb: success");
                end else begin
                    $display("tb: failure");
                end
            end
            begin
                while (cycles < CYCLE_LIMIT) begin
                    @(posedge clk);
                    cycles++;
                end
                $display("tb: failure");
            end
        join_any
        $finish;
    end

endmodule
`default_nettype wire
